@@ hw/rtl/bld_pkg.sv @@
// package with shared constants, types and state codes for the long divider
package bld_pkg;

    localparam int LOW_W = 64;
    localparam int HIGH_W = 32;
    localparam int FULL_W = LOW_W + HIGH_W;
    localparam int OPERAND_WIDTH_DEF = 96;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic capture;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic den_zero;
        logic last;
    } status_t;

endpackage

@@ hw/rtl/bld_if.sv @@
// item channels for the divider: operand request and quotient response
interface bld_req_if;
    logic                         valid;
    logic                         ready;
    logic [bld_pkg::LOW_W-1:0]    dividend_low;
    logic [bld_pkg::HIGH_W-1:0]   dividend_high;
    logic [bld_pkg::LOW_W-1:0]    divisor_low;
    logic [bld_pkg::HIGH_W-1:0]   divisor_high;

    modport source (
        output valid, dividend_low, dividend_high, divisor_low, divisor_high,
        input  ready
    );
    modport sink (
        input  valid, dividend_low, dividend_high, divisor_low, divisor_high,
        output ready
    );
endinterface

interface bld_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [bld_pkg::LOW_W-1:0]    quotient_low;
    logic [bld_pkg::HIGH_W-1:0]   quotient_high;
    logic                         divide_by_zero;

    modport source (
        output valid, quotient_low, quotient_high, divide_by_zero,
        input  ready
    );
    modport sink (
        input  valid, quotient_low, quotient_high, divide_by_zero,
        output ready
    );
endinterface

@@ hw/rtl/bld_dpath.sv @@
// shift and subtract datapath: remainder, dividend/quotient shifter, counter
module bld_dpath #(
    parameter int OPERAND_WIDTH = bld_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bld_pkg::cmd_t                cmd,
    output bld_pkg::status_t             status,
    input  logic [bld_pkg::FULL_W-1:0]   dividend,
    input  logic [bld_pkg::FULL_W-1:0]   divisor,
    output logic [bld_pkg::FULL_W-1:0]   quotient,
    output logic                         divide_by_zero
);

    localparam int W = OPERAND_WIDTH;
    localparam int QW = bld_pkg::FULL_W;
    localparam int CNT_W = $clog2(W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(W - 1);

    logic [W-1:0]     num_opnd;
    logic [W-1:0]     den_opnd;
    logic [QW-1:0]    quo_ext;

    logic [W-1:0]     num_reg, num_next;
    logic [W-1:0]     den_reg, den_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             dbz_reg, dbz_next;
    logic [QW-1:0]    quo_out_reg, quo_out_next;
    logic             dbz_out_reg, dbz_out_next;

    logic [W:0]       shifted;
    logic [W+1:0]     diff;
    logic             ge;

    // operands are the low bits of the input, zero-extended past 96 bits
    generate
        if (W <= QW) begin : g_narrow
            assign num_opnd = dividend[W-1:0];
            assign den_opnd = divisor[W-1:0];
        end else begin : g_wide
            assign num_opnd = {{(W-QW){1'b0}}, dividend};
            assign den_opnd = {{(W-QW){1'b0}}, divisor};
        end
        if (W >= QW) begin : g_q_trunc
            assign quo_ext = num_reg[QW-1:0];
        end else begin : g_q_ext
            assign quo_ext = {{(QW-W){1'b0}}, num_reg};
        end
    endgenerate

    // trial subtract of the divisor from the shifted remainder
    assign shifted = {rem_reg, num_reg[W-1]};
    assign diff = {1'b0, shifted} - {2'b00, den_reg};
    assign ge = ~diff[W+1];

    assign status.den_zero = (den_opnd == '0);
    assign status.last = (cnt_reg == '0);

    always_comb
    begin
        num_next = num_reg;
        den_next = den_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        dbz_next = dbz_reg;
        quo_out_next = quo_out_reg;
        dbz_out_next = dbz_out_reg;
        if (cmd.load)
        begin
            num_next = num_opnd;
            den_next = den_opnd;
            rem_next = '0;
            cnt_next = CNT_LAST;
            dbz_next = status.den_zero;
        end
        else if (cmd.step)
        begin
            // quotient bits enter from the bottom as dividend bits leave the top
            num_next = {num_reg[W-2:0], ge};
            rem_next = ge ? diff[W-1:0] : shifted[W-1:0];
            cnt_next = cnt_reg - 1'b1;
        end
        if (cmd.capture)
        begin
            quo_out_next = dbz_reg ? '0 : quo_ext;
            dbz_out_next = dbz_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        dbz_reg <= dbz_next;
        quo_out_reg <= quo_out_next;
        dbz_out_reg <= dbz_out_next;
    end

    assign quotient = quo_out_reg;
    assign divide_by_zero = dbz_out_reg;

endmodule

@@ hw/rtl/bld_ctrl.sv @@
// sequencing state machine for the divider and the result valid flag
module bld_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  bld_pkg::status_t  status,
    output bld_pkg::cmd_t     cmd
);

    bld_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;
    logic            slot_free;

    assign slot_free = ~out_valid_reg | out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bld_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = status.den_zero ? bld_pkg::ST_HOLD : bld_pkg::ST_RUN;
                end
            end
            bld_pkg::ST_RUN:
            begin
                if (status.last)
                begin
                    state_next = bld_pkg::ST_HOLD;
                end
            end
            bld_pkg::ST_HOLD:
            begin
                if (slot_free)
                begin
                    state_next = bld_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bld_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            bld_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            bld_pkg::ST_RUN:
            begin
                cmd.step = 1'b1;
            end
            bld_pkg::ST_HOLD:
            begin
                cmd.capture = slot_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign out_valid_next = cmd.capture | (out_valid_reg & ~out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bld_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_capture_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> out_valid_reg)
        else $error("result not presented after capture");

    a_capture_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> (!out_valid_reg || out_ready))
        else $error("pending result overwritten");

    a_last_to_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bld_pkg::ST_RUN && status.last) |=> state_reg == bld_pkg::ST_HOLD)
        else $error("run did not end after last step");

    a_zero_div_skips: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && status.den_zero) |=> state_reg == bld_pkg::ST_HOLD)
        else $error("zero divisor did not bypass iteration");
`endif

endmodule

@@ hw/rtl/binary_long_divider_96bit_top.sv @@
// each item is loaded, then iterated once per quotient bit, then captured
// items do not overlap: a new one is taken only after the last is captured;
//   the single shared subtractor steps one quotient bit per cycle
// zero divisor bypasses the iterations and goes from load straight to capture
// reset (rst_n, async, active low) returns the controller to idle with no result pending
// a finished result waits in its output register while the next item is taken
module binary_long_divider_96bit_top #(
    parameter int OPERAND_WIDTH = bld_pkg::OPERAND_WIDTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    bld_req_if.sink   req,
    bld_rsp_if.source rsp
);

    bld_pkg::cmd_t                cmd;
    bld_pkg::status_t             status;
    logic [bld_pkg::FULL_W-1:0]   dividend;
    logic [bld_pkg::FULL_W-1:0]   divisor;
    logic [bld_pkg::FULL_W-1:0]   quotient;
    logic                         in_ready;
    logic                         out_valid;
    logic                         divide_by_zero;

    // assemble the 96-bit operands from their low and high parts
    assign dividend = {req.dividend_high, req.dividend_low};
    assign divisor = {req.divisor_high, req.divisor_low};

    // controller: idle / run / hold sequencing and output valid flag
    bld_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath: restoring shift and subtract, one quotient bit per step
    bld_dpath #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .dividend       (dividend),
        .divisor        (divisor),
        .quotient       (quotient),
        .divide_by_zero (divide_by_zero)
    );

    assign req.ready = in_ready;
    assign rsp.valid = out_valid;
    // split the registered quotient back into its low and high parts
    assign rsp.quotient_low = quotient[bld_pkg::LOW_W-1:0];
    assign rsp.quotient_high = quotient[bld_pkg::FULL_W-1:bld_pkg::LOW_W];
    assign rsp.divide_by_zero = divide_by_zero;

endmodule
